[rtl/core/keyboard_mouse_packet_decoder_defines.svh]
// Assertion macros for the keyboard/mouse packet decoder
`ifndef KEYBOARD_MOUSE_PACKET_DECODER_DEFINES_SVH
`define KEYBOARD_MOUSE_PACKET_DECODER_DEFINES_SVH

// checked only outside reset
`define KMPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define KMPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/kmpd_pkg.sv]
// Types, constants and the scancode table of the keyboard/mouse packet decoder
package kmpd_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 10;
  localparam int ROM_SIZE       = 115;

  localparam logic [7:0] HDR_MIN_RST   = 8'd248;
  localparam logic [7:0] LEFT_CODE_RST = 8'd250;
  localparam logic [9:0] X_LIMIT_RST   = 10'd624;
  localparam logic [8:0] Y_LIMIT_RST   = 9'd384;
  localparam logic [9:0] POS_X_RST     = 10'd320;
  localparam logic [8:0] POS_Y_RST     = 9'd200;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT   = 4'd3;

  // request codes on the input channel
  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_POP,
    OP_UPDATE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DX,
    PH_DY
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] hdr_min;
    logic [7:0] left_code;
    logic [9:0] x_limit;
    logic [8:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_scancode;
    logic [7:0] key_ascii;
    logic       keys_waiting;
    logic       key_held;
    logic [9:0] pointer_x;
    logic [8:0] pointer_y;
    logic       left_click;
    logic       motion_only;
    logic       fifo_overflow;
  } res_t;

  localparam logic [7:0] ASCII_ROM [ROM_SIZE] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
    8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h18, 8'h00, 8'h2D, 8'h1B, 8'h00, 8'h1A, 8'h2B, 8'h00, 8'h19, 8'h00, 8'h00, 8'h7F,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h28, 8'h29, 8'h2F, 8'h2A, 8'h37, 8'h38, 8'h39, 8'h34, 8'h35,
    8'h36, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h0D
  };

  function automatic logic [7:0] ascii_of(input logic [7:0] code);
    logic [7:0] val;
    if (code < 8'(ROM_SIZE)) begin
      val = ASCII_ROM[code[6:0]];
    end else begin
      val = 8'h00;
    end
    return val;
  endfunction

endpackage

[rtl/core/kmpd_if.sv]
// Channel interfaces: request items, result items and config writes
interface kmpd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface kmpd_rsp_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [7:0] key_scancode;
  logic [7:0] key_ascii;
  logic       keys_waiting;
  logic       key_held;
  logic [9:0] pointer_x;
  logic [8:0] pointer_y;
  logic       left_click;
  logic       motion_only;
  logic       fifo_overflow;

  modport source (output valid, output key_valid, output key_scancode, output key_ascii,
                  output keys_waiting, output key_held, output pointer_x, output pointer_y,
                  output left_click, output motion_only, output fifo_overflow,
                  input ready);
  modport sink (input valid, input key_valid, input key_scancode, input key_ascii,
                input keys_waiting, input key_held, input pointer_x, input pointer_y,
                input left_click, input motion_only, input fifo_overflow,
                output ready);
endinterface

interface kmpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kmpd_pkg::CFG_IDX_W-1:0]   index;
  logic [kmpd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/kmpd_ram.sv]
// Generic single-write, single-read RAM with registered read data
module kmpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/kmpd_front.sv]
// Front end: accepts request items, decodes them and queues them for the back end
module kmpd_front (
  input  logic              clk,
  input  logic              rst,
  kmpd_req_if.sink          req,
  output logic              head_valid,
  output kmpd_pkg::cmd_t    head,
  input  logic              head_pop
);
  import kmpd_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_idx;
  logic [QPTR_W-1:0] wr_idx;
  logic [QCNT_W-1:0] count;
  logic              push;
  cmd_t              cmd;

  always_comb begin
    cmd.data = req.rx_byte;
    case (req.req_type)
      REQ_BYTE:   cmd.op = OP_BYTE;
      REQ_POP:    cmd.op = OP_POP;
      REQ_UPDATE: cmd.op = OP_UPDATE;
      REQ_CLEAR:  cmd.op = OP_CLEAR;
      default:    cmd.op = OP_BYTE;
    endcase
  end

  assign req.ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = req.valid && req.ready;
  assign head_valid = (count != '0);
  assign head       = queue[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_idx] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (head_pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case ({push, head_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/kmpd_back.sv]
// Back end: executes queued commands against key FIFO and mouse state, registers results
module kmpd_back #(
  parameter int FIFO_DEPTH = kmpd_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  kmpd_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  kmpd_pkg::cmd_t    head,
  output logic              head_pop,
  output logic              res_valid,
  output kmpd_pkg::res_t    res,
  input  logic              res_ready
);
  import kmpd_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  // signed 8-bit step, clamped to [0, limit]
  function automatic logic [9:0] clamp_add(input logic [9:0] pos, input logic [7:0] delta,
                                           input logic [9:0] limit);
    logic signed [11:0] sum;
    logic [9:0]         v;
    sum = $signed({2'b00, pos}) + $signed({{4{delta[7]}}, delta});
    if (sum[11]) begin
      v = '0;
    end else if (sum[10:0] > {1'b0, limit}) begin
      v = limit;
    end else begin
      v = sum[9:0];
    end
    return v;
  endfunction

  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0] fill, fill_next;
  phase_t           phase, phase_next;
  logic [7:0]       button, button_next;
  logic [7:0]       dx, dx_next;
  logic [7:0]       dy, dy_next;
  logic [9:0]       pos_x, pos_x_next;
  logic [8:0]       pos_y, pos_y_next;
  logic             held, held_next;
  logic             moved, moved_next;
  logic             click, click_next;
  logic             key_hit;
  logic             ovf;
  logic             ram_we;
  logic             ram_re;
  logic [9:0]       y_wide;
  logic [7:0]       ram_rdata;
  logic             exec;

  // result stage
  logic             r_key_valid;
  logic             r_waiting;
  logic             r_held;
  logic [9:0]       r_px;
  logic [8:0]       r_py;
  logic             r_click;
  logic             r_moved;
  logic             r_ovf;

  assign exec     = head_valid && (!res_valid || res_ready);
  assign head_pop = exec;
  assign y_wide   = clamp_add({1'b0, pos_y}, dy, {1'b0, cfg.y_limit});

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    phase_next  = phase;
    button_next = button;
    dx_next     = dx;
    dy_next     = dy;
    pos_x_next  = pos_x;
    pos_y_next  = pos_y;
    held_next   = held;
    moved_next  = moved;
    click_next  = click;
    key_hit     = 1'b0;
    ovf         = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (exec) begin
      case (head.op)
        OP_BYTE: begin
          case (phase)
            PH_DX: begin
              dx_next    = head.data;
              phase_next = PH_DY;
            end
            PH_DY: begin
              dy_next    = head.data;
              phase_next = PH_IDLE;
            end
            default: begin
              if (head.data >= cfg.hdr_min) begin
                button_next = head.data;
                moved_next  = (head.data == cfg.hdr_min);
                phase_next  = PH_DX;
              end else if (!head.data[7]) begin
                if (fill == CNT_W'(FIFO_DEPTH)) begin
                  ovf = 1'b1;
                end else begin
                  ram_we      = 1'b1;
                  wr_ptr_next = bump(wr_ptr);
                  fill_next   = fill + 1'b1;
                end
                held_next = 1'b1;
              end else begin
                held_next  = 1'b0;
                phase_next = PH_IDLE;
              end
            end
          endcase
        end
        OP_POP: begin
          if (fill != '0) begin
            ram_re      = 1'b1;
            key_hit     = 1'b1;
            rd_ptr_next = bump(rd_ptr);
            fill_next   = fill - 1'b1;
          end
        end
        OP_UPDATE: begin
          pos_x_next = clamp_add(pos_x, dx, cfg.x_limit);
          pos_y_next = y_wide[8:0];
          click_next = (button == cfg.left_code);
          dx_next    = '0;
          dy_next    = '0;
        end
        OP_CLEAR: begin
          rd_ptr_next = wr_ptr;
          fill_next   = '0;
        end
        default: begin
          fill_next = fill;
        end
      endcase
    end
  end

  kmpd_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (head.data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      phase     <= PH_IDLE;
      button    <= '0;
      dx        <= '0;
      dy        <= '0;
      pos_x     <= POS_X_RST;
      pos_y     <= POS_Y_RST;
      held      <= 1'b0;
      moved     <= 1'b0;
      click     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      fill      <= fill_next;
      phase     <= phase_next;
      button    <= button_next;
      dx        <= dx_next;
      dy        <= dy_next;
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      held      <= held_next;
      moved     <= moved_next;
      click     <= click_next;
      if (exec) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      r_key_valid <= key_hit;
      r_waiting   <= (fill_next != '0);
      r_held      <= held_next;
      r_px        <= pos_x_next;
      r_py        <= pos_y_next;
      r_click     <= click_next;
      r_moved     <= moved_next;
      r_ovf       <= ovf;
    end
  end

  // scancode comes straight from the RAM read register
  always_comb begin
    res.key_valid     = r_key_valid;
    res.key_scancode  = r_key_valid ? ram_rdata : 8'h00;
    res.key_ascii     = r_key_valid ? ascii_of(ram_rdata) : 8'h00;
    res.keys_waiting  = r_waiting;
    res.key_held      = r_held;
    res.pointer_x     = r_px;
    res.pointer_y     = r_py;
    res.left_click    = r_click;
    res.motion_only   = r_moved;
    res.fifo_overflow = r_ovf;
  end

endmodule

[rtl/core/keyboard_mouse_packet_decoder.sv]
// Keyboard/mouse packet decoder top level: config registers, front end and back end
// An accepted item is written into the front-end queue, then executed by the back end into its result register.
// Throughput: 1 item per cycle unless an untaken result stalls the back end, which executes one
// queued command per cycle; the key FIFO RAM (one write or one registered read per cycle) keeps that pace.
// Reset (rst, synchronous): FIFO empty, pointer at 320/200, flags and deltas clear,
// config at 248/250/624/384. FIFO contents are undefined until written; no clearing pass.
`include "keyboard_mouse_packet_decoder_defines.svh"

module keyboard_mouse_packet_decoder #(
  parameter int FIFO_DEPTH = kmpd_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  kmpd_req_if.sink   req,
  kmpd_rsp_if.source rsp,
  kmpd_cfg_if.sink   cfg
);
  import kmpd_pkg::*;

  cfg_t cfg_regs;
  logic head_valid;
  cmd_t head;
  logic head_pop;
  logic res_valid;
  res_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.hdr_min   <= HDR_MIN_RST;
      cfg_regs.left_code <= LEFT_CODE_RST;
      cfg_regs.x_limit   <= X_LIMIT_RST;
      cfg_regs.y_limit   <= Y_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_HDR_MIN:   cfg_regs.hdr_min   <= cfg.data[7:0];
        CFG_LEFT_CODE: cfg_regs.left_code <= cfg.data[7:0];
        CFG_X_LIMIT:   cfg_regs.x_limit   <= cfg.data[9:0];
        CFG_Y_LIMIT:   cfg_regs.y_limit   <= cfg.data[8:0];
        default:       cfg_regs           <= cfg_regs;
      endcase
    end
  end

  kmpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  kmpd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (rsp.ready)
  );

  assign rsp.valid         = res_valid;
  assign rsp.key_valid     = res.key_valid;
  assign rsp.key_scancode  = res.key_scancode;
  assign rsp.key_ascii     = res.key_ascii;
  assign rsp.keys_waiting  = res.keys_waiting;
  assign rsp.key_held      = res.key_held;
  assign rsp.pointer_x     = res.pointer_x;
  assign rsp.pointer_y     = res.pointer_y;
  assign rsp.left_click    = res.left_click;
  assign rsp.motion_only   = res.motion_only;
  assign rsp.fifo_overflow = res.fifo_overflow;

  // a dropped key means the FIFO was full, so it cannot be empty afterwards
  `KMPD_ASSERT(a_ovf_not_empty, res_valid && res.fifo_overflow |-> res.keys_waiting, "overflow with empty FIFO")
  `KMPD_ASSERT(a_pop_vs_push, res_valid |-> !(res.key_valid && res.fifo_overflow), "pop and overflow in one item")
  `KMPD_ASSERT(a_no_key_zero, res_valid && !res.key_valid |-> (res.key_scancode == 8'h00) && (res.key_ascii == 8'h00), "key fields set without a key")
  `KMPD_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !res_valid, "result offered right after reset")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the keyboard/mouse packet decoder
`timescale 1ns / 100ps

module testbench;
  import kmpd_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int KEY_DEPTH      = FIFO_DEPTH_DEF;
  localparam int SCAN_LEN       = 115;
  localparam int RESULT_LATENCY = 2;

  // scancode to ASCII translation
  localparam logic [7:0] SCAN_TO_ASCII [SCAN_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
    8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h18, 8'h00, 8'h2D, 8'h1B, 8'h00, 8'h1A, 8'h2B, 8'h00, 8'h19, 8'h00, 8'h00, 8'h7F,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h28, 8'h29, 8'h2F, 8'h2A, 8'h37, 8'h38, 8'h39, 8'h34, 8'h35,
    8'h36, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h0D
  };

  logic clk;
  logic rst;

  kmpd_req_if req_ch();
  kmpd_rsp_if rsp_ch();
  kmpd_cfg_if cfg_ch();

  keyboard_mouse_packet_decoder dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // decoder mirror
  cfg_t       cfg_now;
  logic [7:0] key_mem [KEY_DEPTH];
  int         key_rd;
  int         key_wr;
  int         key_count;
  phase_t     pkt_phase;
  logic [7:0] btn_byte;
  logic [7:0] dx_reg;
  logic [7:0] dy_reg;
  int         cur_x;
  int         cur_y;
  logic       held_now;
  logic       moved_now;
  logic       click_now;

  res_t pending_results [$];
  int   errors;
  int   items_sent;
  int   src_idle_pct;
  int   stall_pct;
  int   hold_cycles;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic int clamp_pos(input int pos, input logic [7:0] delta, input int limit);
    int v;
    v = pos + int'($signed(delta));
    if (v < 0) begin
      v = 0;
    end else if (v > limit) begin
      v = limit;
    end
    return v;
  endfunction

  // advance the mirror by one item and queue the result it should produce
  task automatic decode_item(input logic [1:0] kind, input logic [7:0] rx);
    res_t r;
    r = '0;
    case (kind)
      REQ_BYTE: begin
        if (pkt_phase == PH_DX) begin
          dx_reg = rx;
          pkt_phase = PH_DY;
        end else if (pkt_phase == PH_DY) begin
          dy_reg = rx;
          pkt_phase = PH_IDLE;
        end else if (rx >= cfg_now.hdr_min) begin
          btn_byte = rx;
          moved_now = (rx == cfg_now.hdr_min);
          pkt_phase = PH_DX;
        end else if (!rx[7]) begin
          if (key_count >= KEY_DEPTH) begin
            r.fifo_overflow = 1'b1;
          end else begin
            key_mem[key_wr] = rx;
            key_wr = (key_wr + 1) % KEY_DEPTH;
            key_count++;
          end
          held_now = 1'b1;
        end else begin
          held_now = 1'b0;
          pkt_phase = PH_IDLE;
        end
      end
      REQ_POP: begin
        if (key_count > 0) begin
          r.key_valid = 1'b1;
          r.key_scancode = key_mem[key_rd];
          r.key_ascii = (key_mem[key_rd] < SCAN_LEN) ? SCAN_TO_ASCII[key_mem[key_rd]] : 8'h00;
          key_rd = (key_rd + 1) % KEY_DEPTH;
          key_count--;
        end
      end
      REQ_UPDATE: begin
        cur_x = clamp_pos(cur_x, dx_reg, int'(cfg_now.x_limit));
        cur_y = clamp_pos(cur_y, dy_reg, int'(cfg_now.y_limit));
        click_now = (btn_byte == cfg_now.left_code);
        dx_reg = 8'h00;
        dy_reg = 8'h00;
      end
      default: begin
        key_rd = key_wr;
        key_count = 0;
      end
    endcase
    r.keys_waiting = (key_count > 0);
    r.key_held = held_now;
    r.pointer_x = 10'(cur_x);
    r.pointer_y = 9'(cur_y);
    r.left_click = click_now;
    r.motion_only = moved_now;
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing got key %0h x %0d y %0d",
                 $time, rsp_ch.key_scancode, rsp_ch.pointer_x, rsp_ch.pointer_y);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("key_valid", 16'(want.key_valid), 16'(rsp_ch.key_valid));
        check_field("key_scancode", 16'(want.key_scancode), 16'(rsp_ch.key_scancode));
        check_field("key_ascii", 16'(want.key_ascii), 16'(rsp_ch.key_ascii));
        check_field("keys_waiting", 16'(want.keys_waiting), 16'(rsp_ch.keys_waiting));
        check_field("key_held", 16'(want.key_held), 16'(rsp_ch.key_held));
        check_field("pointer_x", 16'(want.pointer_x), 16'(rsp_ch.pointer_x));
        check_field("pointer_y", 16'(want.pointer_y), 16'(rsp_ch.pointer_y));
        check_field("left_click", 16'(want.left_click), 16'(rsp_ch.left_click));
        check_field("motion_only", 16'(want.motion_only), 16'(rsp_ch.motion_only));
        check_field("fifo_overflow", 16'(want.fifo_overflow), 16'(rsp_ch.fifo_overflow));
      end
    end
  end

  // result side: random stalls, or a counted hold-off when one is armed
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic send_req(input logic [1:0] kind, input logic [7:0] rx);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = kind;
    req_ch.rx_byte = rx;
    do @(posedge clk); while (!req_ch.ready);
    decode_item(kind, rx);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [9:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_HDR_MIN:   cfg_now.hdr_min = value[7:0];
      CFG_LEFT_CODE: cfg_now.left_code = value[7:0];
      CFG_X_LIMIT:   cfg_now.x_limit = value[9:0];
      CFG_Y_LIMIT:   cfg_now.y_limit = value[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // unused upper data bits get random values
  task automatic cfg_write_all(input logic [7:0] hdr, input logic [7:0] left,
                               input logic [9:0] xl, input logic [8:0] yl);
    cfg_write(CFG_HDR_MIN, {2'($urandom), hdr});
    cfg_write(CFG_LEFT_CODE, {2'($urandom), left});
    cfg_write(CFG_X_LIMIT, xl);
    cfg_write(CFG_Y_LIMIT, {1'($urandom), yl});
  endtask

  task automatic test_directed();
    send_req(REQ_POP, 8'h00);       // pop on empty FIFO
    send_req(REQ_CLEAR, 8'hFF);
    send_req(REQ_UPDATE, 8'h00);
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'h7F);      // beyond the ROM
    send_req(REQ_BYTE, 8'h72);      // last ROM entry
    send_req(REQ_BYTE, 8'h80);      // break code
    send_req(REQ_POP, 8'h00);
    send_req(REQ_POP, 8'h00);
    send_req(REQ_POP, 8'h00);
    send_req(REQ_BYTE, 8'd248);     // plain movement header
    send_req(REQ_BYTE, 8'h7F);
    send_req(REQ_BYTE, 8'h80);
    send_req(REQ_UPDATE, 8'h00);
    send_req(REQ_BYTE, 8'hFF);
    send_req(REQ_BYTE, 8'h80);
    send_req(REQ_UPDATE, 8'h00);    // update in the middle of a packet
    send_req(REQ_BYTE, 8'hFF);
    send_req(REQ_BYTE, 8'd250);     // left button header
    send_req(REQ_BYTE, 8'h7F);
    send_req(REQ_BYTE, 8'h7F);
    send_req(REQ_UPDATE, 8'hAA);
    send_req(REQ_BYTE, 8'h01);
    send_req(REQ_CLEAR, 8'h00);     // held flag survives a clear
    send_req(REQ_POP, 8'h00);
    wait_idle();
  endtask

  task automatic test_config();
    // indexes past the last register are ignored
    for (int i = 4; i < 16; i++) begin
      cfg_write(4'(i), 10'($urandom));
    end
    send_req(REQ_BYTE, 8'd248);
    send_req(REQ_BYTE, 8'h05);
    send_req(REQ_BYTE, 8'h05);
    send_req(REQ_UPDATE, 8'h00);
    wait_idle();
    // a header below 0x80 wins over a make code
    cfg_write_all(8'h10, 8'h20, 10'd0, 9'd0);
    send_req(REQ_BYTE, 8'h20);
    send_req(REQ_BYTE, 8'h03);
    send_req(REQ_BYTE, 8'h02);
    send_req(REQ_BYTE, 8'h05);
    send_req(REQ_UPDATE, 8'h00);   // pointer clamps down to lowered limits
    wait_idle();
    cfg_write_all(8'h00, 8'h00, 10'd1023, 9'd511);
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'h7F);
    send_req(REQ_BYTE, 8'h7F);
    send_req(REQ_UPDATE, 8'h00);
    wait_idle();
    cfg_write_all(8'hFF, 8'hFF, 10'd1023, 9'd511);
    for (int i = 0; i < 6; i++) begin
      send_req(REQ_BYTE, 8'hFF);
      send_req(REQ_BYTE, 8'h7F);
      send_req(REQ_BYTE, 8'h7F);
      send_req(REQ_UPDATE, 8'h00);
    end
    send_req(REQ_BYTE, 8'hFE);      // break code just below the header
    wait_idle();
    cfg_write_all(HDR_MIN_RST, LEFT_CODE_RST, X_LIMIT_RST, Y_LIMIT_RST);
  endtask

  task automatic test_fifo_overflow();
    for (int i = 0; i < KEY_DEPTH + 3; i++) begin
      send_req(REQ_BYTE, 8'($urandom_range(127)));
    end
    for (int i = 0; i < KEY_DEPTH + 2; i++) begin
      send_req(REQ_POP, 8'($urandom));
    end
    for (int i = 0; i < 10; i++) begin
      send_req(REQ_BYTE, 8'($urandom_range(127)));
    end
    send_req(REQ_CLEAR, 8'($urandom));
    send_req(REQ_POP, 8'($urandom));
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 80;
    for (int i = 0; i < 40; i++) begin
      send_req(2'($urandom), 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_sender_pause();
    src_idle_pct = 34;
    stall_pct = 34;
    for (int i = 0; i < 10; i++) begin
      send_req(2'($urandom), 8'($urandom));
    end
    wait_idle();
    for (int i = 0; i < 10; i++) begin
      send_req(2'($urandom), 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    int upper;
    logic [7:0] hdr;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        hdr = 8'($urandom_range(255, cfg_now.hdr_min));
        if ($urandom_range(3) == 0 && cfg_now.left_code >= cfg_now.hdr_min) begin
          hdr = cfg_now.left_code;
        end else if ($urandom_range(5) == 0) begin
          hdr = cfg_now.hdr_min;
        end
        send_req(REQ_BYTE, hdr);
        send_req(REQ_BYTE, 8'($urandom));
        if ($urandom_range(9) == 0) begin
          send_req(REQ_UPDATE, 8'($urandom));   // truncated packet
        end
        send_req(REQ_BYTE, 8'($urandom));
        if ($urandom_range(4) != 0) begin
          send_req(REQ_UPDATE, 8'($urandom));
        end
      end else if (pick < 65) begin
        upper = (cfg_now.hdr_min < 128) ? int'(cfg_now.hdr_min) : 128;
        if (upper > 0) begin
          send_req(REQ_BYTE, 8'($urandom_range(upper - 1, 0)));
        end else begin
          send_req(REQ_BYTE, 8'($urandom));
        end
        if ($urandom_range(2) == 0 && cfg_now.hdr_min > 128) begin
          send_req(REQ_BYTE, 8'($urandom_range(int'(cfg_now.hdr_min) - 1, 128)));
        end
      end else if (pick < 82) begin
        send_req(REQ_POP, 8'($urandom));
      end else if (pick < 85) begin
        send_req(REQ_CLEAR, 8'($urandom));
      end else begin
        send_req(2'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_random();
    logic [7:0] hdr;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          src_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          src_idle_pct = 58;
          stall_pct = 0;
          hdr = 8'($urandom_range(255, 192));
          cfg_write_all(hdr, 8'($urandom_range(255, hdr)), 10'($urandom),
                        9'($urandom));
        end
        2: begin
          src_idle_pct = 0;
          stall_pct = 58;
          cfg_write_all(8'd128, 8'd200, 10'd1023, 9'd511);
        end
        3: begin
          src_idle_pct = 34;
          stall_pct = 34;
          hdr = 8'($urandom_range(255, 128));
          cfg_write_all(hdr, 8'($urandom), 10'($urandom), 9'($urandom));
        end
        4: begin
          src_idle_pct = 58;
          stall_pct = 58;
          cfg_write_all(8'd255, 8'd255, 10'd0, 9'd0);
        end
        default: begin
          src_idle_pct = 34;
          stall_pct = 34;
          cfg_write_all(8'($urandom_range(255, 100)), 8'($urandom), 10'($urandom),
                        9'($urandom));
        end
      endcase
      run_traffic(190);
    end
    wait_idle();
  endtask

  initial begin
    #(2 * CLK_HALF * 400000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_BYTE;
    req_ch.rx_byte = 8'h00;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_HDR_MIN;
    cfg_ch.data = '0;
    cfg_now.hdr_min = HDR_MIN_RST;
    cfg_now.left_code = LEFT_CODE_RST;
    cfg_now.x_limit = X_LIMIT_RST;
    cfg_now.y_limit = Y_LIMIT_RST;
    key_rd = 0;
    key_wr = 0;
    key_count = 0;
    pkt_phase = PH_IDLE;
    btn_byte = 8'h00;
    dx_reg = 8'h00;
    dy_reg = 8'h00;
    cur_x = int'(POS_X_RST);
    cur_y = int'(POS_Y_RST);
    held_now = 1'b0;
    moved_now = 1'b0;
    click_now = 1'b0;
    errors = 0;
    items_sent = 0;
    src_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_config();
    test_fifo_overflow();
    test_backpressure();
    test_sender_pause();
    test_random();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[keyboard_mouse_packet_decoder.f]
+incdir+rtl/core
rtl/core/kmpd_pkg.sv
rtl/core/kmpd_if.sv
rtl/core/kmpd_ram.sv
rtl/core/kmpd_front.sv
rtl/core/kmpd_back.sv
rtl/core/keyboard_mouse_packet_decoder.sv
tb/testbench.sv
